@@ rtl/ncs_pkg.sv @@
package ncs_pkg;

   localparam int MaxNesting = 16;
   localparam int LevelWidth = $clog2(MaxNesting + 1);
   localparam int NestOutWidth = 5;

   typedef enum logic [2:0] {
      OP_IF    = 3'd0,
      OP_ELIF  = 3'd1,
      OP_ELSE  = 3'd2,
      OP_ENDIF = 3'd3,
      OP_QUERY = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EXPR_ERR = 2'd1,
      ST_NO_IF    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ANS_NONE  = 2'd0,
      ANS_RUN   = 2'd1,
      ANS_CHECK = 2'd2
   } answer_type;

   localparam logic [1:0] CondFalse = 2'd0;
   localparam logic [1:0] CondTrue  = 2'd1;

   // Bit 0 is the error flag, bit 3 the in-else flag.
   typedef struct packed {
      logic in_else;
      logic go;
      logic noop;
      logic err;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic load;
   } cell_ctl_type;

   typedef struct packed {
      status_type st;
      entry_type  ent;
   } branch_type;

   function automatic logic entry_skips(input entry_type e);
      entry_skips = e.noop || !e.go;
   endfunction

   function automatic branch_type eval_branch(input logic skip_now, input logic [1:0] cond);
      branch_type r;
      r.st = ST_OK;
      r.ent = '{in_else: 1'b0, go: 1'b1, noop: skip_now, err: 1'b0};
      if (!skip_now) begin
         if (cond == CondFalse) begin
            r.ent.go = 1'b0;
         end else if (cond != CondTrue) begin
            r.ent.err = 1'b1;
            r.ent.noop = 1'b1;
            r.st = ST_EXPR_ERR;
         end
      end
      eval_branch = r;
   endfunction

endpackage

@@ rtl/ncs_cell.sv @@
module ncs_cell (
   input  logic                 clock,
   input  ncs_pkg::cell_ctl_type ctl,
   input  ncs_pkg::entry_type    above,
   input  ncs_pkg::entry_type    below,
   output ncs_pkg::entry_type    entry
);

   ncs_pkg::entry_type entry_ff;
   ncs_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push || ctl.load) begin
         entry_in = above;
      end else if (ctl.pop) begin
         entry_in = below;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ rtl/nested_conditional_stack_top.sv @@
// A result item is registered and appears in the cycle after its request item is accepted.
// Throughput: one item per cycle while the result side keeps up; the output
// register lets a new item enter in the same cycle the previous result leaves.
// The stack is a row of cells that shift down on if and up on endif.
// Reset empties the stack and drops any pending result; cell contents are not cleared.
module nested_conditional_stack_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[2:0], cond_result[4:3], next_is_branch[5], zero[7:6]
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], query_answer[3:2], nesting_level[8:4], zero[15:9]
   output logic [15:0] rsp_tdata
);

   localparam int Depth = ncs_pkg::MaxNesting;
   localparam int LW = ncs_pkg::LevelWidth;
   localparam int NW = ncs_pkg::NestOutWidth;

   ncs_pkg::op_type      op;
   logic [1:0]           cond;
   logic                 branch;
   logic                 accept;

   logic [LW-1:0]        level_ff;
   logic [LW-1:0]        level_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [15:0]          rsp_data_ff;
   logic [15:0]          rsp_data_in;

   ncs_pkg::entry_type   cell_q [Depth];
   ncs_pkg::entry_type   top;
   ncs_pkg::entry_type   second;
   ncs_pkg::entry_type   new_entry;
   ncs_pkg::branch_type  ev;
   ncs_pkg::status_type  status;
   ncs_pkg::answer_type  answer;
   logic                 push;
   logic                 pop;
   logic                 load;
   logic                 empty;
   logic                 full;
   logic                 toggle;
   logic [NW-1:0]        level_out;

   assign op     = ncs_pkg::op_type'(req_tdata[2:0]);
   assign cond   = req_tdata[4:3];
   assign branch = req_tdata[5];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign top    = cell_q[0];
   assign second = cell_q[1];
   assign empty  = (level_ff == '0);
   assign full   = (level_ff == LW'(Depth));

   always_comb begin
      push      = 1'b0;
      pop       = 1'b0;
      load      = 1'b0;
      new_entry = top;
      status    = ncs_pkg::ST_OK;
      answer    = ncs_pkg::ANS_NONE;
      toggle    = 1'b0;
      ev        = ncs_pkg::eval_branch(!empty && ncs_pkg::entry_skips(top), cond);
      case (op)
         ncs_pkg::OP_IF: begin
            if (full) begin
               status = ncs_pkg::ST_OVERFLOW;
            end else begin
               new_entry = ev.ent;
               status    = ev.st;
               push      = 1'b1;
            end
         end
         ncs_pkg::OP_ELIF: begin
            ev = ncs_pkg::eval_branch(top.noop || top.go, cond);
            if (empty || top.in_else) begin
               status = ncs_pkg::ST_NO_IF;
            end else if (!top.err) begin
               new_entry = ev.ent;
               status    = ev.st;
               load      = 1'b1;
            end
         end
         ncs_pkg::OP_ELSE: begin
            if (empty || top.in_else) begin
               status = ncs_pkg::ST_NO_IF;
            end else begin
               new_entry.go      = !top.go;
               new_entry.in_else = 1'b1;
               load              = 1'b1;
            end
         end
         ncs_pkg::OP_ENDIF: begin
            if (empty) begin
               status = ncs_pkg::ST_NO_IF;
            end else begin
               pop = 1'b1;
            end
         end
         ncs_pkg::OP_QUERY: begin
            if (!empty) begin
               if (ncs_pkg::entry_skips(top)) begin
                  toggle = branch && !(level_ff >= LW'(2) && ncs_pkg::entry_skips(second));
                  answer = toggle ? ncs_pkg::ANS_NONE : ncs_pkg::ANS_CHECK;
               end else begin
                  answer = branch ? ncs_pkg::ANS_CHECK : ncs_pkg::ANS_RUN;
               end
            end
         end
         default: begin
         end
      endcase
   end

   genvar i;
   generate
      for (i = 0; i < Depth; i++) begin : g_cell
         ncs_pkg::cell_ctl_type ctl;
         ncs_pkg::entry_type    above;
         ncs_pkg::entry_type    below;
         if (i == 0) begin : g_head
            assign above = new_entry;
            assign ctl   = '{push: accept && push, pop: accept && pop,
                             load: accept && load};
         end else begin : g_body
            assign above = cell_q[i-1];
            assign ctl   = '{push: accept && push, pop: accept && pop, load: 1'b0};
         end
         if (i == Depth - 1) begin : g_tail
            assign below = '0;
         end else begin : g_link
            assign below = cell_q[i+1];
         end
         ncs_cell u_cell (
            .clock (clock),
            .ctl   (ctl),
            .above (above),
            .below (below),
            .entry (cell_q[i])
         );
      end
   endgenerate

   always_comb begin
      level_in = level_ff;
      if (accept && push) begin
         level_in = level_ff + LW'(1);
      end else if (accept && pop) begin
         level_in = level_ff - LW'(1);
      end
   end

   assign level_out = NW'(level_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, level_out, answer, status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(Depth))
      else $error("stack level above capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && op == ncs_pkg::OP_IF && !full |=> level_ff == $past(level_ff) + LW'(1))
      else $error("if did not push");

   a_query_holds: assert property (@(posedge clock) disable iff (reset)
      accept && op == ncs_pkg::OP_QUERY |=> $stable(level_ff) && rsp_tdata[1:0] == 2'd0)
      else $error("query changed the stack or reported a status");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ncs_pkg::ST_OVERFLOW |-> level_ff == LW'(Depth))
      else $error("overflow reported on a stack that is not full");

endmodule
